[rtl/osset_pkg.sv]
package osset_pkg;

  // Set capacity and derived widths
  localparam int CAPACITY = 1024;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths
  localparam int KEY_W  = 32;
  localparam int RANK_W = 11;
  localparam int LESS_W = 11;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;

  // Reduction tree: cells are OR-combined in groups, then across groups
  localparam int GROUP  = 32;
  localparam int NGROUP = (CAPACITY + GROUP - 1) / GROUP;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_SELECT = 2'd2;
  localparam logic [OP_W-1:0] OP_COUNT  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic signed [KEY_W-1:0] key_value;
    logic [RANK_W-1:0] rank;
  } in_beat_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] found_value;
    logic [LESS_W-1:0] less_count;
    logic [STAT_W-1:0] status;
  } out_beat_t;

  // What one cell contributes to the wired-OR reduction
  typedef struct packed {
    logic             hit;   // first cell not below the key
    logic             eq;    // cell holds the key
    logic [KEY_W-1:0] val;   // selected cell's value, else zero
    logic [IDX_W-1:0] pos;   // index of the hit cell, else zero
  } contrib_t;

  // Commands broadcast to every cell
  typedef struct packed {
    logic cmp;
    logic ins;
    logic del;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_RED1,
    S_RED2,
    S_APPLY
  } state_t;

endpackage

[rtl/osset_cell.sv]
module osset_cell (
  input  logic                          clk,
  input  osset_pkg::cell_cmd_t          cmd,
  input  logic [osset_pkg::IDX_W-1:0]   idx,
  input  logic [osset_pkg::CNT_W-1:0]   count,
  input  osset_pkg::key_t               key,
  input  logic [osset_pkg::RANK_W-1:0]  rank_m1,
  input  osset_pkg::key_t               left_val,
  input  logic                          left_lt,
  input  osset_pkg::key_t               right_val,
  output osset_pkg::key_t               val,
  output logic                          lt,
  output osset_pkg::contrib_t           contrib
);

  osset_pkg::key_t val_r, val_nxt;
  logic lt_r, eq_r, sel_r;
  logic occ;

  assign occ = 32'(idx) < 32'(count);

  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      lt_r  <= occ && (val_r < key);
      eq_r  <= occ && (val_r == key);
      sel_r <= occ && (32'(idx) == 32'(rank_m1));
    end
    val_r <= val_nxt;
  end

  // Insert shifts right from the insertion point, delete shifts left
  always_comb begin
    val_nxt = val_r;
    if (cmd.ins && !lt_r) begin
      val_nxt = left_lt ? key : left_val;
    end else if (cmd.del && !lt_r) begin
      val_nxt = right_val;
    end
  end

  always_comb begin
    contrib.hit = left_lt && !lt_r;
    contrib.eq  = eq_r;
    contrib.val = sel_r ? val_r : '0;
    contrib.pos = contrib.hit ? idx : '0;
  end

  assign val = val_r;
  assign lt  = lt_r;

endmodule

[rtl/osset_reduce.sv]
module osset_reduce (
  input  logic                clk,
  input  osset_pkg::contrib_t cin [osset_pkg::CAPACITY],
  output osset_pkg::contrib_t total
);

  osset_pkg::contrib_t grp_r   [osset_pkg::NGROUP];
  osset_pkg::contrib_t grp_nxt [osset_pkg::NGROUP];
  osset_pkg::contrib_t total_r, total_nxt;

  // First level: OR within each group
  always_comb begin
    for (int g = 0; g < osset_pkg::NGROUP; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < osset_pkg::GROUP; j++) begin
        if (g * osset_pkg::GROUP + j < osset_pkg::CAPACITY) begin
          grp_nxt[g] = osset_pkg::contrib_t'(grp_nxt[g] | cin[g * osset_pkg::GROUP + j]);
        end
      end
    end
  end

  // Second level: OR across groups
  always_comb begin
    total_nxt = '0;
    for (int g = 0; g < osset_pkg::NGROUP; g++) begin
      total_nxt = osset_pkg::contrib_t'(total_nxt | grp_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    grp_r   <= grp_nxt;
    total_r <= total_nxt;
  end

  assign total = total_r;

endmodule

[rtl/order_statistic_set.sv]
// Channel  Dir  Handshake          Beat
// in_      in   in_valid/in_stall   opcode, key_value, rank
// out_     out  out_valid/out_stall found_value, less_count, status
//
// Items are taken one at a time: accept, compare in all cells, two levels of
// the registered OR tree over the cells, then apply (shift and result load).
// Reset clears the element count and the handshake state; cell values are
// not reset, only cells below the count are ever looked at.
// A waiting result stalls the apply step; no new item is taken meanwhile.
module order_statistic_set (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  osset_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output osset_pkg::out_beat_t out_data
);

  osset_pkg::state_t state_r, state_nxt;

  // Latched operation
  logic [osset_pkg::OP_W-1:0]   op_r;
  osset_pkg::key_t              key_r;
  logic [osset_pkg::RANK_W-1:0] rank_r;
  logic [osset_pkg::RANK_W-1:0] rank_m1;

  logic [osset_pkg::CNT_W-1:0] count_r, count_nxt;

  logic                 out_valid_r, out_valid_nxt;
  osset_pkg::out_beat_t out_data_r, out_data_nxt;

  osset_pkg::cell_cmd_t cmd;
  osset_pkg::contrib_t  total;
  logic [osset_pkg::CNT_W-1:0] pos;
  logic accept;
  logic full;
  logic rank_ok;

  // Cell chain wiring
  osset_pkg::key_t     cell_val [osset_pkg::CAPACITY];
  logic                cell_lt  [osset_pkg::CAPACITY];
  osset_pkg::contrib_t contrib  [osset_pkg::CAPACITY];

  assign accept  = in_valid && !in_stall;
  assign in_stall = (state_r != osset_pkg::S_IDLE);
  assign rank_m1 = rank_r - osset_pkg::RANK_W'(1);

  // Chain of sorted cells: cell i sees its left and right neighbor
  for (genvar i = 0; i < osset_pkg::CAPACITY; i++) begin : g_cell
    osset_pkg::key_t lval, rval;
    logic            llt;

    if (i == 0) begin : g_first
      assign lval = key_r;
      assign llt  = 1'b1;
    end else begin : g_mid
      assign lval = cell_val[i-1];
      assign llt  = cell_lt[i-1];
    end

    if (i == osset_pkg::CAPACITY - 1) begin : g_last
      assign rval = cell_val[i];
    end else begin : g_right
      assign rval = cell_val[i+1];
    end

    osset_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .idx       (osset_pkg::IDX_W'(i)),
      .count     (count_r),
      .key       (key_r),
      .rank_m1   (rank_m1),
      .left_val  (lval),
      .left_lt   (llt),
      .right_val (rval),
      .val       (cell_val[i]),
      .lt        (cell_lt[i]),
      .contrib   (contrib[i])
    );
  end

  osset_reduce u_reduce (
    .clk   (clk),
    .cin   (contrib),
    .total (total)
  );

  // Lower bound: the hit cell, or the count when every stored value is below
  assign pos     = total.hit ? osset_pkg::CNT_W'(total.pos) : count_r;
  assign full    = (count_r == osset_pkg::CNT_W'(osset_pkg::CAPACITY));
  assign rank_ok = (rank_r != '0) && (32'(rank_r) <= 32'(count_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= osset_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_data.opcode;
      key_r  <= in_data.key_value;
      rank_r <= in_data.rank;
    end
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;

    case (state_r)
      osset_pkg::S_IDLE: begin
        if (in_valid) state_nxt = osset_pkg::S_CMP;
      end
      osset_pkg::S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = osset_pkg::S_RED1;
      end
      osset_pkg::S_RED1: begin
        state_nxt = osset_pkg::S_RED2;
      end
      osset_pkg::S_RED2: begin
        state_nxt = osset_pkg::S_APPLY;
      end
      osset_pkg::S_APPLY: begin
        // hold until the output register is free
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          state_nxt     = osset_pkg::S_IDLE;
          case (op_r)
            osset_pkg::OP_INSERT: begin
              if (!total.eq) begin
                if (full) begin
                  out_data_nxt.status = osset_pkg::ST_FULL;
                end else begin
                  cmd.ins   = 1'b1;
                  count_nxt = count_r + osset_pkg::CNT_W'(1);
                end
              end
            end
            osset_pkg::OP_DELETE: begin
              if (total.eq) begin
                cmd.del   = 1'b1;
                count_nxt = count_r - osset_pkg::CNT_W'(1);
              end
            end
            osset_pkg::OP_SELECT: begin
              if (rank_ok) begin
                out_data_nxt.found_value = total.val;
              end else begin
                out_data_nxt.status = osset_pkg::ST_INVALID;
              end
            end
            osset_pkg::OP_COUNT: begin
              out_data_nxt.less_count = osset_pkg::LESS_W'(pos);
            end
            default: begin
              out_data_nxt = '0;
            end
          endcase
        end
      end
      default: begin
        state_nxt = osset_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/osset_chk.sv]
module osset_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input osset_pkg::out_beat_t out_data
);

  // A waiting result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // One item at a time: an accepted beat closes the input
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after accept");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= osset_pkg::ST_FULL)
    else $error("undefined status code");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == osset_pkg::ST_INVALID |->
      out_data.found_value == '0 && out_data.less_count == '0)
    else $error("invalid rank result carries data");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == osset_pkg::ST_FULL |->
      out_data.found_value == '0 && out_data.less_count == '0)
    else $error("full result carries data");

endmodule

bind order_statistic_set osset_chk u_osset_chk (.*);
